/* design/frc_pkg.sv */
`default_nettype none
package frc_pkg;
   localparam int SLOT_COUNT = 64;
   localparam int SLOT_BITS = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int MAX_COPIES = 4;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      FUNC_LOOKUP = 2'd0,
      FUNC_FILL   = 2'd1,
      FUNC_WRITE  = 2'd2,
      FUNC_SYNC   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      REG_FAT_KNOWN  = 2'd0,
      REG_FAT_FIRST  = 2'd1,
      REG_FAT_LENGTH = 2'd2,
      REG_FAT_COPIES = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] sector;
   } req_type;

   typedef struct packed {
      logic        in_fat;
      logic        hit;
      logic [5:0]  slot_index;
      logic        writeback;
      logic [5:0]  writeback_slot;
      logic [31:0] writeback_sector;
      logic        last;
   } rsp_type;

   // classified transaction handed from front to back
   typedef struct packed {
      logic [1:0]  func;
      logic        in_fat;
      logic [31:0] sector;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DECIDE,
      ST_VICTIM,
      ST_SYNC,
      ST_SYNC_OUT
   } back_state_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_CHECK
   } front_state_type;
endpackage
`default_nettype wire

/* design/fat_region_write_back_sector_cache_top.sv */
// FAT-region sector cache metadata controller. A request is taken when start is high and busy
// is low; each result appears for one cycle with rsp_valid and cannot be stalled. The front
// checks FAT copies one per cycle (up to 4), then pushes the job; a two-entry queue decouples
// it from the back, which walks all 64 tag slots one per cycle through the tag RAM read port.
// A non-sync request outside the FAT is answered without a scan, and an allocation miss adds
// a victim step after the scan. A sync reports its dirty slots during the scan, and the
// last of them (or a single empty result when nothing was dirty) follows the scan with last set.
`default_nettype none
module fat_region_write_back_sector_cache_top import frc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  req_type          req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   logic known_ff;
   logic [31:0] first_ff, length_ff;
   logic [2:0] copies_ff;
   logic q_full, q_push, q_ne, q_pop;
   job_type q_in, q_head;
   reg_index_type ridx;
   rsp_type rraw;

   assign pready = 1'b1;
   assign ridx = reg_index_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         known_ff <= 1'b0;
         first_ff <= '0;
         length_ff <= '0;
         copies_ff <= '0;
      end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
         case (ridx)
            REG_FAT_KNOWN:  known_ff <= pwdata[0];
            REG_FAT_FIRST:  first_ff <= pwdata;
            REG_FAT_LENGTH: length_ff <= pwdata;
            REG_FAT_COPIES: copies_ff <= pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (ridx)
         REG_FAT_KNOWN:  prdata = {31'd0, known_ff};
         REG_FAT_FIRST:  prdata = first_ff;
         REG_FAT_LENGTH: prdata = length_ff;
         REG_FAT_COPIES: prdata = {29'd0, copies_ff};
         default:        prdata = '0;
      endcase
   end

   frc_front u_front (
      .clock, .reset, .start, .req_data,
      .fat_known(known_ff), .fat_first(first_ff), .fat_length(length_ff),
      .fat_copies(copies_ff), .q_full, .busy, .q_push, .q_data(q_in)
   );

   frc_queue u_queue (
      .clock, .reset, .push(q_push), .push_data(q_in), .pop(q_pop),
      .full(q_full), .not_empty(q_ne), .head(q_head)
   );

   frc_back u_back (
      .clock, .reset, .q_valid(q_ne), .q_head, .q_pop,
      .rsp_valid, .rsp_data(rraw)
   );

   assign rsp_data = rraw;
endmodule
`default_nettype wire

/* design/frc_front.sv */
`default_nettype none
module frc_front import frc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  req_type          req_data,
   input  wire logic        fat_known,
   input  wire logic [31:0] fat_first,
   input  wire logic [31:0] fat_length,
   input  wire logic [2:0]  fat_copies,
   input  wire logic        q_full,
   output logic             busy,
   output logic             q_push,
   output job_type          q_data
);
   front_state_type state_ff, state_in;
   req_type req_ff, req_in;
   logic [2:0] copy_ff, copy_in;
   logic [31:0] lo_ff, lo_in;
   logic hitr_ff, hitr_in;
   logic [2:0] ncopies;
   logic [31:0] hi;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
      req_ff <= req_in;
      copy_ff <= copy_in;
      lo_ff <= lo_in;
      hitr_ff <= hitr_in;
   end

   assign ncopies = (fat_copies > 3'(MAX_COPIES)) ? 3'(MAX_COPIES) : fat_copies;
   assign hi = lo_ff + fat_length;

   // one FAT copy checked per cycle
   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      copy_in = copy_ff;
      lo_in = lo_ff;
      hitr_in = hitr_ff;
      q_push = 1'b0;
      q_data = '{func: req_ff.func, in_fat: hitr_ff, sector: req_ff.sector};
      busy = (state_ff != FR_IDLE) || q_full;
      case (state_ff)
         FR_IDLE: begin
            if (start && !q_full) begin
               req_in = req_data;
               copy_in = '0;
               lo_in = fat_first;
               hitr_in = 1'b0;
               state_in = FR_CHECK;
            end
         end
         FR_CHECK: begin
            if (!fat_known || copy_ff >= ncopies || hitr_ff) begin
               q_push = 1'b1;
               state_in = FR_IDLE;
            end else begin
               if (req_ff.sector >= lo_ff && req_ff.sector < hi) hitr_in = 1'b1;
               lo_in = hi;
               copy_in = copy_ff + 3'd1;
            end
         end
         default: state_in = FR_IDLE;
      endcase
   end
endmodule
`default_nettype wire

/* design/frc_queue.sv */
`default_nettype none
module frc_queue import frc_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  job_type   push_data,
   input  wire logic pop,
   output logic      full,
   output logic      not_empty,
   output job_type   head
);
   localparam int PW = $clog2(QUEUE_DEPTH);
   job_type mem_ff [QUEUE_DEPTH];
   logic [PW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [PW:0] cnt_ff, cnt_in;

   assign full = cnt_ff == (PW+1)'(QUEUE_DEPTH);
   assign not_empty = cnt_ff != '0;
   assign head = mem_ff[rp_ff];

   always_comb begin
      wp_in = push ? wp_ff + PW'(1) : wp_ff;
      rp_in = pop ? rp_ff + PW'(1) : rp_ff;
      cnt_in = cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= push_data;
   end
endmodule
`default_nettype wire

/* design/frc_back.sv */
`default_nettype none
module frc_back import frc_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic q_valid,
   input  job_type   q_head,
   output logic      q_pop,
   output logic      rsp_valid,
   output rsp_type   rsp_data
);
   back_state_type state_ff, state_in;
   job_type job_ff, job_in;
   logic [SLOT_BITS-1:0] idx_ff, idx_in;
   logic found_ff, found_in;
   logic [SLOT_BITS-1:0] fslot_ff, fslot_in;
   logic [SLOT_BITS-1:0] vic_ff, vic_in;
   logic any_ff, any_in;
   rsp_type held_ff, held_in;
   logic [SLOT_COUNT-1:0] valid_ff, dirty_ff;
   logic [31:0] tag_mem [SLOT_COUNT];
   logic [31:0] tag_rd_ff;
   logic [SLOT_BITS-1:0] rd_addr;
   logic tag_we;
   logic [SLOT_BITS-1:0] tag_wa;
   logic set_valid, dirty_we, dirty_val;
   logic [SLOT_BITS-1:0] dirty_wa;
   logic out_v_ff, out_v_in;
   rsp_type out_ff, out_in;
   localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(SLOT_COUNT - 1);

   assign rsp_valid = out_v_ff;
   assign rsp_data = out_ff;

   always_ff @(posedge clock) begin
      tag_rd_ff <= tag_mem[rd_addr];
      if (tag_we) tag_mem[tag_wa] <= job_ff.sector;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         dirty_ff <= '0;
         vic_ff <= '0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         vic_ff <= vic_in;
         out_v_ff <= out_v_in;
         if (set_valid) valid_ff[tag_wa] <= 1'b1;
         if (dirty_we) dirty_ff[dirty_wa] <= dirty_val;
      end
      job_ff <= job_in;
      idx_ff <= idx_in;
      found_ff <= found_in;
      fslot_ff <= fslot_in;
      any_ff <= any_in;
      held_ff <= held_in;
      out_ff <= out_in;
   end

   // tag search reads one slot per cycle; read data is registered in tag_rd_ff
   always_comb begin
      state_in = state_ff;
      job_in = job_ff;
      idx_in = idx_ff;
      found_in = found_ff;
      fslot_in = fslot_ff;
      vic_in = vic_ff;
      any_in = any_ff;
      held_in = held_ff;
      q_pop = 1'b0;
      rd_addr = idx_ff;
      tag_we = 1'b0;
      tag_wa = vic_ff;
      set_valid = 1'b0;
      dirty_we = 1'b0;
      dirty_val = 1'b0;
      dirty_wa = fslot_ff;
      out_v_in = 1'b0;
      out_in = '0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               job_in = q_head;
               idx_in = '0;
               found_in = 1'b0;
               any_in = 1'b0;
               rd_addr = '0;
               if (q_head.func == FUNC_SYNC) begin
                  state_in = ST_SYNC;
               end else if (!q_head.in_fat) begin
                  out_v_in = 1'b1;
                  out_in.last = 1'b1;
               end else begin
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            // tag_rd_ff holds slot idx_ff
            if (!found_ff && valid_ff[idx_ff] && tag_rd_ff == job_ff.sector) begin
               found_in = 1'b1;
               fslot_in = idx_ff;
            end
            if (idx_ff == LAST_SLOT) begin
               state_in = ST_DECIDE;
               rd_addr = vic_ff;
            end else begin
               idx_in = idx_ff + SLOT_BITS'(1);
               rd_addr = idx_in;
            end
         end
         ST_DECIDE: begin
            rd_addr = vic_ff;
            if (found_ff) begin
               out_v_in = 1'b1;
               out_in.in_fat = 1'b1;
               out_in.hit = 1'b1;
               out_in.slot_index = 6'(fslot_ff);
               out_in.last = 1'b1;
               if (job_ff.func != FUNC_LOOKUP) begin
                  dirty_we = 1'b1;
                  dirty_val = job_ff.func == FUNC_WRITE;
               end
               state_in = ST_IDLE;
            end else if (job_ff.func == FUNC_LOOKUP) begin
               out_v_in = 1'b1;
               out_in.in_fat = 1'b1;
               out_in.last = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_VICTIM;
            end
         end
         ST_VICTIM: begin
            out_v_in = 1'b1;
            out_in.in_fat = 1'b1;
            out_in.slot_index = 6'(vic_ff);
            out_in.last = 1'b1;
            if (valid_ff[vic_ff] && dirty_ff[vic_ff]) begin
               out_in.writeback = 1'b1;
               out_in.writeback_slot = 6'(vic_ff);
               out_in.writeback_sector = tag_rd_ff;
            end
            tag_we = 1'b1;
            tag_wa = vic_ff;
            set_valid = 1'b1;
            dirty_we = 1'b1;
            dirty_wa = vic_ff;
            dirty_val = job_ff.func == FUNC_WRITE;
            vic_in = (vic_ff == LAST_SLOT) ? '0 : vic_ff + SLOT_BITS'(1);
            state_in = ST_IDLE;
         end
         ST_SYNC: begin
            // tag_rd_ff holds slot idx_ff; each writeback is held back one find
            // so the final one can carry last
            if (valid_ff[idx_ff] && dirty_ff[idx_ff]) begin
               if (any_ff) begin
                  out_v_in = 1'b1;
                  out_in = held_ff;
               end
               held_in = '0;
               held_in.writeback = 1'b1;
               held_in.writeback_slot = 6'(idx_ff);
               held_in.writeback_sector = tag_rd_ff;
               dirty_we = 1'b1;
               dirty_wa = idx_ff;
               dirty_val = 1'b0;
               any_in = 1'b1;
            end
            if (idx_ff == LAST_SLOT) begin
               state_in = ST_SYNC_OUT;
            end else begin
               idx_in = idx_ff + SLOT_BITS'(1);
               rd_addr = idx_in;
            end
         end
         ST_SYNC_OUT: begin
            // last held writeback, or a bare marker when nothing was dirty
            out_v_in = 1'b1;
            if (any_ff) out_in = held_ff;
            out_in.last = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire
